[sv/flash_download_sequencer_top_assert.svh]
// ----------------------------------------------------------------------------
// Flash download sequencer assertion macros
// Concurrent assertion helpers used by the sequencer top level.
// ----------------------------------------------------------------------------
`ifndef FLASH_DOWNLOAD_SEQUENCER_TOP_ASSERT_SVH
`define FLASH_DOWNLOAD_SEQUENCER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[sv/fds_pkg.sv]
// ----------------------------------------------------------------------------
// Flash download sequencer package
// Field widths, request and status codes, phase encoding and shared types.
// ----------------------------------------------------------------------------
package fds_pkg;

  localparam int KIND_W    = 3;
  localparam int SESS_W    = 8;
  localparam int KEY_W     = 32;
  localparam int SIZE_W    = 32;
  localparam int BLKNUM_W  = 8;
  localparam int BLKLEN_W  = 13;
  localparam int STATUS_W  = 3;
  localparam int PHCODE_W  = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [BLKLEN_W-1:0] MAX_BLOCK_BYTES = BLKLEN_W'(4096);
  localparam logic [KEY_W-1:0]    SECURITY_KEY_RST = 32'hDEAD_BEEF;
  localparam logic [SESS_W-1:0]   SESSION_CODE_RST = 8'h02;

  localparam logic REG_SECURITY_KEY  = 1'b0;
  localparam logic REG_SESSION_CODE  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SESSION  = 3'd0,
    KIND_SECURITY = 3'd1,
    KIND_DOWNLOAD = 3'd2,
    KIND_BLOCK    = 3'd3,
    KIND_EXIT     = 3'd4,
    KIND_VERIFY   = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_WRONG_STATE  = 3'd1,
    ST_BAD_SESSION  = 3'd2,
    ST_BAD_KEY      = 3'd3,
    ST_SEQ_MISMATCH = 3'd4,
    ST_INCOMPLETE   = 3'd5
  } status_e;

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_SESSION  = 8'b0000_0010,
    PH_UNLOCKED = 8'b0000_0100,
    PH_STARTED  = 8'b0000_1000,
    PH_TRANSFER = 8'b0001_0000,
    PH_DONE     = 8'b0010_0000,
    PH_VERIFIED = 8'b0100_0000,
    PH_ERROR    = 8'b1000_0000
  } phase_e;

  localparam logic [PHCODE_W-1:0] PHCODE_IDLE     = 3'd0;
  localparam logic [PHCODE_W-1:0] PHCODE_SESSION  = 3'd1;
  localparam logic [PHCODE_W-1:0] PHCODE_UNLOCKED = 3'd2;
  localparam logic [PHCODE_W-1:0] PHCODE_STARTED  = 3'd3;
  localparam logic [PHCODE_W-1:0] PHCODE_TRANSFER = 3'd4;
  localparam logic [PHCODE_W-1:0] PHCODE_DONE     = 3'd5;
  localparam logic [PHCODE_W-1:0] PHCODE_VERIFIED = 3'd6;
  localparam logic [PHCODE_W-1:0] PHCODE_ERROR    = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SESS_W-1:0]   session_code;
    logic [KEY_W-1:0]    key_value;
    logic [SIZE_W-1:0]   download_size;
    logic [BLKNUM_W-1:0] block_number;
    logic [BLKLEN_W-1:0] block_length;
  } req_t;

  typedef struct packed {
    logic                accepted;
    logic [STATUS_W-1:0] status;
    logic [PHCODE_W-1:0] new_state;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  security_key;
    logic [SESS_W-1:0] session_code;
  } cfg_t;

  function automatic logic [PHCODE_W-1:0] phase_code(phase_e ph);
    logic [PHCODE_W-1:0] code;
    unique case (ph)
      PH_IDLE:     code = PHCODE_IDLE;
      PH_SESSION:  code = PHCODE_SESSION;
      PH_UNLOCKED: code = PHCODE_UNLOCKED;
      PH_STARTED:  code = PHCODE_STARTED;
      PH_TRANSFER: code = PHCODE_TRANSFER;
      PH_DONE:     code = PHCODE_DONE;
      PH_VERIFIED: code = PHCODE_VERIFIED;
      PH_ERROR:    code = PHCODE_ERROR;
      default:     code = PHCODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

[sv/fds_req_if.sv]
// ----------------------------------------------------------------------------
// Flash download sequencer request channel
// Valid/ready channel carrying one diagnostic programming request.
// ----------------------------------------------------------------------------
interface fds_req_if;
  logic                          valid;
  logic                          ready;
  logic [fds_pkg::KIND_W-1:0]    kind;
  logic [fds_pkg::SESS_W-1:0]    session_code;
  logic [fds_pkg::KEY_W-1:0]     key_value;
  logic [fds_pkg::SIZE_W-1:0]    download_size;
  logic [fds_pkg::BLKNUM_W-1:0]  block_number;
  logic [fds_pkg::BLKLEN_W-1:0]  block_length;

  modport source (
    output valid, kind, session_code, key_value, download_size, block_number,
           block_length,
    input  ready
  );

  modport sink (
    input  valid, kind, session_code, key_value, download_size, block_number,
           block_length,
    output ready
  );
endinterface

[sv/fds_rsp_if.sv]
// ----------------------------------------------------------------------------
// Flash download sequencer result channel
// Valid/ready channel carrying the outcome of one request.
// ----------------------------------------------------------------------------
interface fds_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [fds_pkg::STATUS_W-1:0]  status;
  logic [fds_pkg::PHCODE_W-1:0]  new_state;

  modport source (
    output valid, accepted, status, new_state,
    input  ready
  );

  modport sink (
    input  valid, accepted, status, new_state,
    output ready
  );
endinterface

[sv/fds_apb_regs.sv]
// ----------------------------------------------------------------------------
// Flash download sequencer configuration registers
// APB-style register file holding the security key and the session code.
// ----------------------------------------------------------------------------
module fds_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fds_pkg::APB_AW-1:0]    paddr,
  input  logic [fds_pkg::APB_DW-1:0]    pwdata,
  output logic [fds_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output fds_pkg::cfg_t                 cfg_o
);

  logic                          wr_en;
  logic                          reg_sel;
  logic [fds_pkg::KEY_W-1:0]     key_q, key_d;
  logic [fds_pkg::SESS_W-1:0]    sess_q, sess_d;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[fds_pkg::APB_AW-1];

  always_comb begin
    key_d  = key_q;
    sess_d = sess_q;
    if (wr_en) begin
      unique case (reg_sel)
        fds_pkg::REG_SECURITY_KEY: key_d  = pwdata[fds_pkg::KEY_W-1:0];
        fds_pkg::REG_SESSION_CODE: sess_d = pwdata[fds_pkg::SESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fds_pkg::REG_SECURITY_KEY: prdata = fds_pkg::APB_DW'(key_q);
      fds_pkg::REG_SESSION_CODE: prdata = fds_pkg::APB_DW'(sess_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= fds_pkg::SECURITY_KEY_RST;
      sess_q <= fds_pkg::SESSION_CODE_RST;
    end else begin
      key_q  <= key_d;
      sess_q <= sess_d;
    end
  end

  assign cfg_o.security_key = key_q;
  assign cfg_o.session_code = sess_q;

endmodule

[sv/fds_core.sv]
// ----------------------------------------------------------------------------
// Flash download sequencer core
// Sequencer phase, download counters and the per-request decision logic.
// ----------------------------------------------------------------------------
module fds_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  fds_pkg::req_t  req_i,
  input  fds_pkg::cfg_t  cfg_i,
  output fds_pkg::rsp_t  rsp_o
);

  fds_pkg::phase_e                 phase_q, phase_d;
  logic [fds_pkg::SIZE_W-1:0]      total_q, total_d;
  logic [fds_pkg::SIZE_W-1:0]      rcvd_q, rcvd_d;
  logic [fds_pkg::BLKNUM_W-1:0]    blk_q, blk_d;
  logic [fds_pkg::BLKLEN_W-1:0]    len_sat;
  fds_pkg::status_e                status;

  assign len_sat = (req_i.block_length > fds_pkg::MAX_BLOCK_BYTES) ?
                   fds_pkg::MAX_BLOCK_BYTES : req_i.block_length;

  always_comb begin
    phase_d = phase_q;
    total_d = total_q;
    rcvd_d  = rcvd_q;
    blk_d   = blk_q;
    status  = fds_pkg::ST_WRONG_STATE;
    unique case (req_i.kind)
      fds_pkg::KIND_SESSION: begin
        if (req_i.session_code == cfg_i.session_code) begin
          phase_d = fds_pkg::PH_SESSION;
          status  = fds_pkg::ST_OK;
        end else begin
          status  = fds_pkg::ST_BAD_SESSION;
        end
      end
      fds_pkg::KIND_SECURITY: begin
        if (phase_q == fds_pkg::PH_SESSION) begin
          if (req_i.key_value == cfg_i.security_key) begin
            phase_d = fds_pkg::PH_UNLOCKED;
            status  = fds_pkg::ST_OK;
          end else begin
            status  = fds_pkg::ST_BAD_KEY;
          end
        end
      end
      fds_pkg::KIND_DOWNLOAD: begin
        if (phase_q == fds_pkg::PH_UNLOCKED) begin
          total_d = req_i.download_size;
          rcvd_d  = '0;
          blk_d   = fds_pkg::BLKNUM_W'(1);
          phase_d = fds_pkg::PH_STARTED;
          status  = fds_pkg::ST_OK;
        end
      end
      fds_pkg::KIND_BLOCK: begin
        if (phase_q == fds_pkg::PH_STARTED || phase_q == fds_pkg::PH_TRANSFER) begin
          if (req_i.block_number != blk_q) begin
            phase_d = fds_pkg::PH_ERROR;
            status  = fds_pkg::ST_SEQ_MISMATCH;
          end else begin
            phase_d = fds_pkg::PH_TRANSFER;
            rcvd_d  = rcvd_q +
                      {{(fds_pkg::SIZE_W-fds_pkg::BLKLEN_W){1'b0}}, len_sat};
            blk_d   = blk_q + fds_pkg::BLKNUM_W'(1);
            status  = fds_pkg::ST_OK;
          end
        end
      end
      fds_pkg::KIND_EXIT: begin
        if (phase_q == fds_pkg::PH_TRANSFER) begin
          if (rcvd_q < total_q) begin
            status  = fds_pkg::ST_INCOMPLETE;
          end else begin
            phase_d = fds_pkg::PH_DONE;
            status  = fds_pkg::ST_OK;
          end
        end
      end
      fds_pkg::KIND_VERIFY: begin
        if (phase_q == fds_pkg::PH_DONE) begin
          phase_d = fds_pkg::PH_VERIFIED;
          status  = fds_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fds_pkg::PH_IDLE;
      total_q <= '0;
      rcvd_q  <= '0;
      blk_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      total_q <= total_d;
      rcvd_q  <= rcvd_d;
      blk_q   <= blk_d;
    end
  end

  assign rsp_o.accepted  = (status == fds_pkg::ST_OK);
  assign rsp_o.status    = status;
  assign rsp_o.new_state = fds_pkg::phase_code(phase_d);

endmodule

[sv/flash_download_sequencer_top.sv]
// ----------------------------------------------------------------------------
// Flash download sequencer top level
// Two-stage request pipeline around the sequencer core and its registers.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each one produces exactly one
// result on the rsp channel, in order. A result reports whether the request
// succeeded, a status code and the sequencer phase after the request.
// An accepted request is held in an input register. The core decides it
// from there, and the phase, the counters and the result register load
// together once the result register is empty or being taken, so a result
// is registered behind the input register. One request per cycle is
// sustained while the receiver takes results.
// When the receiver stalls, the result register holds its item and the
// input register absorbs one more request before req.ready drops.
// Reset clears the valid flags of both pipeline stages, returns the phase
// to idle, zeroes the counters and loads the default key and session code.
// The APB port writes and reads the key and session code; pready is
// always high. Write registers only while no request is in flight.
// ----------------------------------------------------------------------------
`include "flash_download_sequencer_top_assert.svh"

module flash_download_sequencer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fds_req_if.sink                     req,
  fds_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fds_pkg::APB_AW-1:0]  paddr,
  input  logic [fds_pkg::APB_DW-1:0]  pwdata,
  output logic [fds_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  fds_pkg::cfg_t  cfg;
  fds_pkg::req_t  s1_q, s1_d;
  fds_pkg::rsp_t  res_q, res_d;
  fds_pkg::rsp_t  core_rsp;
  logic           s1_v_q, s1_v_d;
  logic           res_v_q, res_v_d;
  logic           s1_load;
  logic           res_load;

  fds_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fds_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (res_load),
    .req_i  (s1_q),
    .cfg_i  (cfg),
    .rsp_o  (core_rsp)
  );

  assign res_load  = s1_v_q && (!res_v_q || rsp.ready);
  assign req.ready = !s1_v_q || res_load;
  assign s1_load   = req.valid && req.ready;

  always_comb begin
    s1_d    = s1_q;
    res_d   = res_q;
    s1_v_d  = s1_v_q;
    res_v_d = res_v_q;
    if (res_load) begin
      res_d   = core_rsp;
      res_v_d = 1'b1;
      s1_v_d  = 1'b0;
    end else if (rsp.ready) begin
      res_v_d = 1'b0;
    end
    if (s1_load) begin
      s1_d.kind          = req.kind;
      s1_d.session_code  = req.session_code;
      s1_d.key_value     = req.key_value;
      s1_d.download_size = req.download_size;
      s1_d.block_number  = req.block_number;
      s1_d.block_length  = req.block_length;
      s1_v_d             = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    res_q <= res_d;
  end

  assign rsp.valid     = res_v_q;
  assign rsp.accepted  = res_q.accepted;
  assign rsp.status    = res_q.status;
  assign rsp.new_state = res_q.new_state;

  `FDS_ASSERT(a_accepted_matches_status, clk_i, rst_ni,
    rsp.valid |-> (rsp.accepted == (rsp.status == fds_pkg::ST_OK)),
    "accepted flag disagrees with status")
  `FDS_ASSERT(a_mismatch_goes_error, clk_i, rst_ni,
    rsp.valid && rsp.status == fds_pkg::ST_SEQ_MISMATCH |-> rsp.new_state == fds_pkg::PHCODE_ERROR,
    "sequence mismatch did not enter the error phase")
  `FDS_ASSERT(a_request_not_dropped, clk_i, rst_ni,
    s1_v_q && !res_load |=> s1_v_q,
    "pending request lost from input stage")
  `FDS_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    res_v_q && !rsp.ready && res_load,
    "result register overwritten while stalled")

endmodule
